// File: sv/uqp_pkg.sv
// shared types, character codes and helper functions for the query string parser
`timescale 1ns / 1ps

package uqp_pkg;

    localparam int unsigned MAX_RES = 6;

    localparam logic [2:0] KIND_KEY_BYTE   = 3'd0;
    localparam logic [2:0] KIND_VALUE_BYTE = 3'd1;
    localparam logic [2:0] KIND_KEY_END    = 3'd2;
    localparam logic [2:0] KIND_PAIR_END   = 3'd3;
    localparam logic [2:0] KIND_QUERY_END  = 3'd4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } uqp_res_t;

    // all results caused by one input byte, in order
    typedef struct packed {
        logic [2:0]                 cnt;
        uqp_res_t [MAX_RES-1:0]     res;
    } uqp_bundle_t;

    function automatic uqp_bundle_t push_res(uqp_bundle_t b, logic [2:0] kind,
                                             logic [7:0] data);
        uqp_bundle_t r;
        r = b;
        if (b.cnt != 3'(MAX_RES))
        begin
            r.res[b.cnt].kind = kind;
            r.res[b.cnt].data = data;
            r.cnt = b.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nib(logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39)
            v = c[3:0];
        else
            v = c[3:0] + 4'd9;
        return v;
    endfunction

endpackage

// File: sv/uqp_if.sv
// valid/ready channel interfaces for query bytes and decoded results
`timescale 1ns / 1ps

interface uqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface uqp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] decoded_byte;
    logic       run_last;

    modport source (output valid, output kind, output decoded_byte, output run_last,
                    input ready);
    modport sink   (input valid, input kind, input decoded_byte, input run_last,
                    output ready);
endinterface

// File: sv/uqp_front.sv
// front end: pair and escape tracking, builds the result bundle of each byte
`timescale 1ns / 1ps

module uqp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    uqp_in_if.sink               query,
    input  logic                 q_full,
    output logic                 push,
    output uqp_pkg::uqp_bundle_t push_bundle
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_KEY   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_SKIP  = 2'd3;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_TWO  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] esc_reg, esc_next;
    logic [7:0] held_reg, held_next;

    logic                 accept;
    uqp_pkg::uqp_bundle_t bnd;
    logic [1:0]           nph;
    logic [1:0]           es;
    logic [7:0]           hd;
    logic [7:0]           d;
    logic                 do_feed, do_flush, key_end, pair_end, fire;
    logic [2:0]           k_old, k_new;

    assign query.ready = !q_full;
    assign accept      = query.valid && !q_full;

    always_comb
    begin
        bnd      = '0;
        nph      = phase_reg;
        es       = (esc_reg == ESC_TWO || esc_reg == ESC_ONE) ? esc_reg : ESC_NONE;
        hd       = held_reg;
        d        = (query.text_byte == uqp_pkg::CH_PLUS) ? uqp_pkg::CH_SPACE
                                                         : query.text_byte;
        do_feed  = 1'b0;
        do_flush = 1'b0;
        key_end  = 1'b0;
        pair_end = 1'b0;
        fire     = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                if (query.text_byte == uqp_pkg::CH_AMP)
                    nph = PH_START;
                else if (query.text_byte == uqp_pkg::CH_EQUALS)
                    nph = PH_SKIP;
                else
                begin
                    nph     = PH_KEY;
                    do_feed = 1'b1;
                end
            end
            PH_KEY:
            begin
                if (query.text_byte == uqp_pkg::CH_AMP)
                begin
                    do_flush = 1'b1;
                    key_end  = 1'b1;
                    pair_end = 1'b1;
                    nph      = PH_START;
                end
                else if (query.text_byte == uqp_pkg::CH_EQUALS)
                begin
                    do_flush = 1'b1;
                    key_end  = 1'b1;
                    nph      = PH_VALUE;
                end
                else
                    do_feed = 1'b1;
            end
            PH_VALUE:
            begin
                if (query.text_byte == uqp_pkg::CH_AMP)
                begin
                    do_flush = 1'b1;
                    pair_end = 1'b1;
                    nph      = PH_START;
                end
                else
                    do_feed = 1'b1;
            end
            PH_SKIP:
            begin
                if (query.text_byte == uqp_pkg::CH_AMP)
                    nph = PH_START;
                es = ESC_NONE;
            end
        endcase

        k_old = (phase_reg == PH_VALUE) ? uqp_pkg::KIND_VALUE_BYTE : uqp_pkg::KIND_KEY_BYTE;
        k_new = (nph == PH_VALUE) ? uqp_pkg::KIND_VALUE_BYTE : uqp_pkg::KIND_KEY_BYTE;

        // data byte: resolve a pending escape first, then the byte itself
        if (do_feed)
        begin
            fire = 1'b1;
            if (es == ESC_ONE)
            begin
                if (uqp_pkg::is_hex(d))
                begin
                    hd   = d;
                    es   = ESC_TWO;
                    fire = 1'b0;
                end
                else
                begin
                    bnd = uqp_pkg::push_res(bnd, k_new, uqp_pkg::CH_PERCENT);
                    es  = ESC_NONE;
                end
            end
            else if (es == ESC_TWO)
            begin
                if (uqp_pkg::is_hex(d) && uqp_pkg::is_hex(hd))
                begin
                    bnd  = uqp_pkg::push_res(bnd, k_new,
                               {uqp_pkg::hex_nib(hd), uqp_pkg::hex_nib(d)});
                    es   = ESC_NONE;
                    fire = 1'b0;
                end
                else
                begin
                    bnd = uqp_pkg::push_res(bnd, k_new, uqp_pkg::CH_PERCENT);
                    bnd = uqp_pkg::push_res(bnd, k_new, hd);
                    es  = ESC_NONE;
                end
            end
            if (fire)
            begin
                if (d == uqp_pkg::CH_PERCENT)
                    es = ESC_ONE;
                else
                    bnd = uqp_pkg::push_res(bnd, k_new, d);
            end
        end

        // delimiter: a cut-short escape goes out literally
        if (do_flush)
        begin
            if (es != ESC_NONE)
                bnd = uqp_pkg::push_res(bnd, k_old, uqp_pkg::CH_PERCENT);
            if (es == ESC_TWO)
                bnd = uqp_pkg::push_res(bnd, k_old, hd);
            es = ESC_NONE;
        end
        if (key_end)
            bnd = uqp_pkg::push_res(bnd, uqp_pkg::KIND_KEY_END, 8'h00);
        if (pair_end)
            bnd = uqp_pkg::push_res(bnd, uqp_pkg::KIND_PAIR_END, 8'h00);

        if (query.final_byte)
        begin
            if (nph == PH_KEY || nph == PH_VALUE)
            begin
                if (es != ESC_NONE)
                    bnd = uqp_pkg::push_res(bnd, k_new, uqp_pkg::CH_PERCENT);
                if (es == ESC_TWO)
                    bnd = uqp_pkg::push_res(bnd, k_new, hd);
            end
            if (nph == PH_KEY)
                bnd = uqp_pkg::push_res(bnd, uqp_pkg::KIND_KEY_END, 8'h00);
            if (nph == PH_KEY || nph == PH_VALUE)
                bnd = uqp_pkg::push_res(bnd, uqp_pkg::KIND_PAIR_END, 8'h00);
            bnd = uqp_pkg::push_res(bnd, uqp_pkg::KIND_QUERY_END, 8'h00);
        end

        if (query.final_byte)
        begin
            phase_next = PH_START;
            esc_next   = ESC_NONE;
            held_next  = 8'h00;
        end
        else
        begin
            phase_next = nph;
            esc_next   = es;
            held_next  = hd;
        end
    end

    // bytes that cause no result never enter the queue
    assign push        = accept && (bnd.cnt != 3'd0);
    assign push_bundle = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            esc_reg   <= ESC_NONE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: sv/uqp_queue.sv
// short bundle queue between the front and back ends
`timescale 1ns / 1ps

module uqp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  uqp_pkg::uqp_bundle_t push_bundle,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output uqp_pkg::uqp_bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uqp_pkg::uqp_bundle_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/uqp_back.sv
// back end: walks each bundle into the output register, one result per cycle unless stalled
`timescale 1ns / 1ps

module uqp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  uqp_pkg::uqp_bundle_t head,
    output logic                 pop,
    uqp_out_if.source            result
);

    logic       out_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [2:0] idx_reg;
    logic       load, at_last;

    assign load    = head_valid && (!out_valid_reg || result.ready);
    assign at_last = (idx_reg == head.cnt - 3'd1);
    assign pop     = load && at_last;

    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.decoded_byte = data_reg;
    assign result.run_last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (load)
                idx_reg <= at_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head.res[idx_reg].kind;
            data_reg <= head.res[idx_reg].data;
            last_reg <= at_last;
        end
    end

endmodule

// File: sv/url_query_string_parser.sv
// top level of the streaming url query string parser
// Usage: raw query bytes enter on the query channel (text_byte, final_byte set on
// the last byte of a query). Decoded key and value bytes and the key-end,
// pair-end and query-end markers leave on the result channel; run_last marks
// the last result caused by one input byte.
// Path: the first result of a byte is written into the queue, then loaded into
// the output register, from which it can leave when the back end is idle.
// Throughput: one byte per cycle while each byte causes at most one result and
// result.ready stays high; a byte that causes several results holds the output
// register until all have left; the back end moves one result per cycle while
// result.ready is high. Bytes causing no result never enter the queue. The queue
// of QUEUE_DEPTH bundles keeps the front end taking bytes while a burst drains.
// Reset: state returns to the start of a pair with no escape pending, the queue
// is emptied and result.valid drops.
// Stall: while result.ready is low the output register holds; the queue fills
// and then query.ready drops until the back end frees an entry.
`timescale 1ns / 1ps

module url_query_string_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    uqp_in_if.sink    query,
    uqp_out_if.source result
);

    logic                 push, q_full, pop, head_valid;
    uqp_pkg::uqp_bundle_t push_bundle, head;

    uqp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query       (query),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    uqp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head        (head)
    );

    uqp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: sv/uqp_checker.sv
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps

module uqp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       r_valid,
    input logic       r_ready,
    input logic [2:0] r_kind,
    input logic [7:0] r_data,
    input logic       r_last
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_kind) && $stable(r_data)
                                && $stable(r_last))
        else $error("result changed while stalled");

    // query end is always the last result of its byte
    a_query_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_kind == uqp_pkg::KIND_QUERY_END |-> r_last)
        else $error("query end without run_last");

    // markers carry a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && (r_kind == uqp_pkg::KIND_KEY_END || r_kind == uqp_pkg::KIND_PAIR_END
                    || r_kind == uqp_pkg::KIND_QUERY_END) |-> r_data == 8'h00)
        else $error("marker with nonzero byte");

    // a key end is never followed by a key byte within the same byte's burst
    a_key_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_ready && r_kind == uqp_pkg::KIND_KEY_END && !r_last
        |=> !(r_valid && r_kind == uqp_pkg::KIND_KEY_BYTE))
        else $error("key byte after key end in one burst");

endmodule

bind url_query_string_parser uqp_checker u_uqp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_kind  (result.kind),
    .r_data  (result.decoded_byte),
    .r_last  (result.run_last)
);
